/* rtl/unsigned_integer_ascii_formatter_defines.svh */
// Assertion macros for the unsigned integer ASCII formatter.
// Used by the top level only; expects clk and rst in scope.
`ifndef UNSIGNED_INTEGER_ASCII_FORMATTER_DEFINES_SVH
`define UNSIGNED_INTEGER_ASCII_FORMATTER_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define UIAF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uiaf assertion failed");
// next-cycle implication
`define UIAF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uiaf assertion failed");
`else
`define UIAF_ASSERT_IMP(lbl, ante, cons)
`define UIAF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* rtl/uiaf_pkg.sv */
// Shared types, codes and the digit-to-ASCII function of the formatter.
// No dependencies.
package uiaf_pkg;

  // base modes
  localparam logic [1:0] MODE_DEC   = 2'd0;
  localparam logic [1:0] MODE_OCT   = 2'd1;
  localparam logic [1:0] MODE_HEXLO = 2'd2;
  localparam logic [1:0] MODE_HEXUP = 2'd3;

  // length kinds (any other code keeps 32 bits)
  localparam logic [1:0] LEN_32 = 2'd0;
  localparam logic [1:0] LEN_64 = 2'd1;
  localparam logic [1:0] LEN_16 = 2'd2;

  // digit string: 22 digits covers a 64-bit value in octal
  localparam int NDIG   = 22;
  localparam int NDIG_W = 5;

  // precision limit
  localparam logic [5:0] PREC_MAX = 6'd62;

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // ASCII codes
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_LO_A  = 7'h61;
  localparam logic [6:0] CH_UP_A  = 7'h41;
  localparam logic [6:0] CH_LO_X  = 7'h78;
  localparam logic [6:0] CH_UP_X  = 7'h58;

  typedef logic [NDIG-1:0][3:0] digits_t;

  // one formatted item, laid out by character position
  typedef struct packed {
    digits_t    digs;     // digit values, least significant first
    logic       upper;    // upper case hex letters
    logic [1:0] plen;     // prefix length
    logic [6:0] n_chars;  // total characters, at least one
    logic [6:0] dig_at;   // first digit position
    logic [6:0] pfx_at;   // first prefix position
    logic [6:0] zero_at;  // fill is '0' from here on, ' ' before
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [6:0] digit_char(input logic [3:0] d, input logic up);
    logic [6:0] c;
    if (d < 4'd10) c = CH_ZERO + {3'b0, d};
    else c = (up ? CH_UP_A : CH_LO_A) + {3'b0, d} - 7'd10;
    return c;
  endfunction

endpackage

/* rtl/uiaf_queue.sv */
// Short FIFO of planned items between the front and back parts.
// Depends on uiaf_pkg.
module uiaf_queue import uiaf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output entry_t head,
  output qstat_t stat
);

  entry_t              slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign stat.full  = (count == QCNT_W'(QDEPTH));
  assign stat.empty = (count == '0);
  assign head       = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

/* rtl/uiaf_front.sv */
// Front part: accepts an item, converts the value to digits and plans the
// character layout, then pushes the plan to the queue. Depends on uiaf_pkg.
module uiaf_front import uiaf_pkg::*; #(
  parameter int MAX_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [63:0] value,
  input  logic [1:0]  length_kind,
  input  logic        zero_pad_flag,
  input  logic        alt_form_flag,
  input  logic [6:0]  field_width,
  input  logic [6:0]  min_digits,
  input  qstat_t      q_stat,
  output logic        q_push,
  output entry_t      q_data
);

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_COUNT, S_PLAN} state_t;

  state_t             state;
  logic [63:0]        sr;
  logic [79:0]        bcd;
  digits_t            digs;
  logic [4:0]         steps;
  logic               upper;
  logic [1:0]         mode_r;
  logic               zpad_r;
  logic               alt_r;
  logic               prec_given;
  logic [5:0]         prec;
  logic [6:0]         width_r;
  logic               nonzero;
  logic [NDIG_W-1:0]  nd;

  // one double-dabble step: add 3 to digits at or above 5, then shift in
  function automatic logic [79:0] dabble(input logic [79:0] b, input logic s);
    logic [79:0] t;
    t = b;
    for (int d = 0; d < 20; d++) begin
      if (t[4*d +: 4] >= 4'd5) t[4*d +: 4] = t[4*d +: 4] + 4'd3;
    end
    return {t[78:0], s};
  endfunction

  // input decode
  logic [63:0] trunc;
  logic [5:0]  p_sat;
  logic        drop;
  logic        accept;
  logic [6:0]  w_sat;
  digits_t     digs_direct;
  logic [65:0] ext;

  always_comb begin
    case (length_kind)
      LEN_64:  trunc = value;
      LEN_16:  trunc = {48'b0, value[15:0]};
      default: trunc = {32'b0, value[31:0]};
    endcase
    p_sat  = (min_digits[5:0] > PREC_MAX) ? PREC_MAX : min_digits[5:0];
    drop   = (trunc == '0) && !min_digits[6] && (min_digits[5:0] == '0);
    w_sat  = (field_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : field_width;
    accept = in_valid && !in_stall;
    ext    = {2'b0, trunc};
    for (int j = 0; j < NDIG; j++) begin
      if (mode == MODE_OCT) digs_direct[j] = {1'b0, ext[3*j +: 3]};
      else if (j < 16) digs_direct[j] = trunc[4*j +: 4];
      else digs_direct[j] = '0;
    end
  end

  assign in_stall = (state != S_IDLE);

  // four conversion bits per cycle
  logic [79:0] bcd_next;
  always_comb begin
    bcd_next = bcd;
    for (int k = 0; k < 4; k++) bcd_next = dabble(bcd_next, sr[63 - k]);
  end

  // leading digit search
  logic [NDIG_W-1:0] nd_next;
  always_comb begin
    nd_next = NDIG_W'(1);
    for (int j = 0; j < NDIG; j++) begin
      if (digs[j] != '0) nd_next = NDIG_W'(j + 1);
    end
  end

  // layout plan
  logic [6:0] nd7, pz, plen7, total, n_chars, pad;
  logic [1:0] plen;
  logic       zero_pad;
  always_comb begin
    nd7      = {2'b0, nd};
    pz       = (prec_given && ({1'b0, prec} > nd7)) ? {1'b0, prec} - nd7 : 7'd0;
    if (!nonzero || !alt_r) plen = 2'd0;
    else if (mode_r == MODE_OCT) plen = 2'd1;
    else if (mode_r == MODE_DEC) plen = 2'd0;
    else plen = 2'd2;
    plen7    = {5'b0, plen};
    total    = nd7 + pz + plen7;
    n_chars  = (width_r > total) ? width_r : total;
    pad      = n_chars - total;
    zero_pad = zpad_r && !prec_given;
    q_data.digs    = digs;
    q_data.upper   = upper;
    q_data.plen    = plen;
    q_data.n_chars = n_chars;
    q_data.dig_at  = n_chars - nd7;
    q_data.pfx_at  = zero_pad ? 7'd0 : pad;
    q_data.zero_at = zero_pad ? 7'd0 : pad + plen7;
  end

  assign q_push = (state == S_PLAN) && !q_stat.full;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && !drop) begin
            mode_r     <= mode;
            upper      <= (mode == MODE_HEXUP);
            zpad_r     <= zero_pad_flag;
            alt_r      <= alt_form_flag;
            prec_given <= !min_digits[6];
            prec       <= p_sat;
            width_r    <= w_sat;
            nonzero    <= (trunc != '0);
            if (mode == MODE_DEC) begin
              bcd <= '0;
              case (length_kind)
                LEN_64: begin
                  sr    <= trunc;
                  steps <= 5'd16;
                end
                LEN_16: begin
                  sr    <= {trunc[15:0], 48'b0};
                  steps <= 5'd4;
                end
                default: begin
                  sr    <= {trunc[31:0], 32'b0};
                  steps <= 5'd8;
                end
              endcase
              state <= S_CONV;
            end else begin
              digs  <= digs_direct;
              state <= S_COUNT;
            end
          end
        end
        S_CONV: begin
          bcd   <= bcd_next;
          sr    <= {sr[59:0], 4'b0};
          steps <= steps - 1'b1;
          digs  <= {8'b0, bcd_next};
          if (steps == 5'd1) state <= S_COUNT;
        end
        S_COUNT: begin
          nd    <= nd_next;
          state <= S_PLAN;
        end
        S_PLAN: begin
          if (!q_stat.full) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/uiaf_back.sv */
// Back part: takes a planned item from the queue and emits its characters
// one per cycle, unless out_stall holds them, through an output register. Depends on uiaf_pkg.
module uiaf_back import uiaf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  entry_t     q_head,
  input  qstat_t     q_stat,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] char_code,
  output logic       last_char
);

  entry_t     cur;
  logic       busy;
  logic [5:0] idx;

  // character at the current position
  logic [6:0]        i7;
  logic [6:0]        dpos;
  logic [NDIG_W-1:0] dsel;
  logic [6:0]        ch;
  logic              is_last;
  logic              emit;
  always_comb begin
    i7   = {1'b0, idx};
    dpos = cur.n_chars - 7'd1 - i7;
    dsel = dpos[NDIG_W-1:0];
    if (i7 >= cur.dig_at) begin
      ch = digit_char(cur.digs[dsel], cur.upper);
    end else if ((cur.plen != 2'd0) && (i7 >= cur.pfx_at)
                 && (i7 < cur.pfx_at + {5'b0, cur.plen})) begin
      if (i7 == cur.pfx_at) ch = CH_ZERO;
      else ch = cur.upper ? CH_UP_X : CH_LO_X;
    end else if (i7 >= cur.zero_at) begin
      ch = CH_ZERO;
    end else begin
      ch = CH_SPACE;
    end
    is_last = (i7 == cur.n_chars - 7'd1);
    emit    = busy && (!out_valid || !out_stall);
  end

  assign q_pop = !busy && !q_stat.empty;

  // payload
  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_head;
    if (emit) begin
      char_code <= ch;
      last_char <= is_last;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (emit) begin
        if (is_last) busy <= 1'b0;
        else idx <= idx + 1'b1;
      end
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

/* rtl/unsigned_integer_ascii_formatter.sv */
// Top level of the unsigned integer ASCII formatter (%u, %o, %x, %X).
// Depends on uiaf_pkg, uiaf_front, uiaf_queue, uiaf_back and the defines header.
//
// Each item gives its characters on the output channel one per transfer,
// the final one flagged by last_char. The front takes an item and, for
// decimal only, converts it with a double-dabble converter that retires
// four bits per cycle; it then counts the digits and plans the layout
// before the plan sits in a two-entry queue. The back loads a plan from
// the queue and emits N characters, where N is the larger of the field
// width and the formatted length (at most 64). Both parts run at once, so
// the front can take a new item while the back still emits an earlier one.
// A zero value with precision zero is accepted and produces no characters.
`include "unsigned_integer_ascii_formatter_defines.svh"
module unsigned_integer_ascii_formatter import uiaf_pkg::*; #(
  parameter int MAX_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [63:0] value,
  input  logic [1:0]  length_kind,
  input  logic        zero_pad_flag,
  input  logic        alt_form_flag,
  input  logic [6:0]  field_width,
  input  logic [6:0]  min_digits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  char_code,
  output logic        last_char
);

  entry_t q_data;
  entry_t q_head;
  qstat_t q_stat;
  logic   q_push;
  logic   q_pop;

  uiaf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .value         (value),
    .length_kind   (length_kind),
    .zero_pad_flag (zero_pad_flag),
    .alt_form_flag (alt_form_flag),
    .field_width   (field_width),
    .min_digits    (min_digits),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_data        (q_data)
  );

  uiaf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  uiaf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_head    (q_head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_code (char_code),
    .last_char (last_char)
  );

  // queue discipline between the two parts
  `UIAF_ASSERT_IMP(a_no_push_full, q_stat.full, !q_push)
  `UIAF_ASSERT_IMP(a_no_pop_empty, q_stat.empty, !q_pop)
  `UIAF_ASSERT_NXT(a_push_fills, q_push && !q_pop, !q_stat.empty)

endmodule

/* test/uiaf_text_checker.sv */
// Scoreboard for the unsigned integer ASCII formatter: predicts the character
// stream of every request taken and compares each character transfer in order.
// Depends on uiaf_pkg for the mode, length and ASCII codes.
module uiaf_text_checker import uiaf_pkg::*; #(
  parameter int MAX_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [63:0] value,
  input  logic [1:0]  length_kind,
  input  logic        zero_pad_flag,
  input  logic        alt_form_flag,
  input  logic [6:0]  field_width,
  input  logic [6:0]  min_digits,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [6:0]  char_code,
  input  logic        last_char,
  output int          errors,
  output int          pending,
  output int          chars_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PREC_LIMIT = 62;

  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } char_exp_t;

  // characters still owed by the block, oldest first
  char_exp_t text_q[$];

  task automatic push_char(input logic [6:0] c);
    char_exp_t ce;
    ce.code = c;
    ce.last = 1'b0;
    text_q.push_back(ce);
  endtask

  // printf-style %u/%o/%x/%X expansion of one request
  task automatic predict_text(input logic [1:0] md, input logic [63:0] val,
                              input logic [1:0] lk, input logic zp, input logic af,
                              input logic [6:0] fw, input logic [6:0] pr);
    logic [63:0] n;
    logic [63:0] t;
    logic [63:0] base;
    logic [3:0]  digs [0:23];
    logic [3:0]  d;
    logic        upper;
    logic        zfill;
    int          width, prec, nd, pz, plen, total, i;
    char_exp_t   ce;
    width = int'(fw);
    if (width > MAX_WIDTH) width = MAX_WIDTH;
    prec = int'($signed(pr));
    if (prec > PREC_LIMIT) prec = PREC_LIMIT;

    // length truncation; unknown kinds keep 32 bits
    case (lk)
      LEN_64:  n = val;
      LEN_16:  n = {48'd0, val[15:0]};
      default: n = {32'd0, val[31:0]};
    endcase

    // zero with precision zero prints nothing at all
    if (n == 64'd0 && prec == 0) return;

    base  = (md == MODE_DEC) ? 64'd10 : (md == MODE_OCT) ? 64'd8 : 64'd16;
    upper = (md == MODE_HEXUP);

    // digits, least significant first
    nd = 0;
    if (n == 64'd0) begin
      digs[0] = 4'd0;
      nd = 1;
    end else begin
      t = n;
      while (t != 64'd0) begin
        digs[nd] = 4'(t % base);
        t = t / base;
        nd++;
      end
    end

    pz = (prec > nd) ? prec - nd : 0;
    plen = 0;
    if (n != 64'd0 && af) begin
      if (md == MODE_OCT) plen = 1;
      else if (md != MODE_DEC) plen = 2;
    end
    total = nd + pz + plen;
    zfill = zp && (prec < 0);

    // prefix goes ahead of pad zeros, but after pad spaces
    if (zfill && plen > 0) begin
      push_char(CH_ZERO);
      if (plen == 2) push_char(upper ? CH_UP_X : CH_LO_X);
    end
    for (i = total; i < width; i++) push_char(zfill ? CH_ZERO : CH_SPACE);
    if (!zfill && plen > 0) begin
      push_char(CH_ZERO);
      if (plen == 2) push_char(upper ? CH_UP_X : CH_LO_X);
    end
    for (i = 0; i < pz; i++) push_char(CH_ZERO);
    for (i = nd - 1; i >= 0; i--) begin
      d = digs[i];
      if (d < 4'd10) push_char(CH_ZERO + {3'd0, d});
      else push_char((upper ? CH_UP_A : CH_LO_A) + {3'd0, d} - 7'd10);
    end

    // flag the final character of this request
    ce = text_q.pop_back();
    ce.last = 1'b1;
    text_q.push_back(ce);
  endtask

  task automatic flag_mismatch(input string what, input logic [6:0] want,
                               input logic [6:0] got);
    errors++;
    if (errors <= 10)
      $display("MISMATCH %s at char %0d: expected %h, got %h", what, chars_seen, want, got);
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin : sample
    char_exp_t got;
    if (rst) begin
      errors = 0;
      chars_seen = 0;
    end else begin
      if (in_valid && !in_stall)
        predict_text(mode, value, length_kind, zero_pad_flag, alt_form_flag,
                     field_width, min_digits);
      if (out_valid && !out_stall) begin
        if (text_q.size() == 0) begin
          flag_mismatch("unexpected char_code", 7'd0, char_code);
        end else begin
          got = text_q.pop_front();
          if (char_code !== got.code) flag_mismatch("char_code", got.code, char_code);
          if (last_char !== got.last) flag_mismatch("last_char", {6'd0, got.last},
                                                    {6'd0, last_char});
        end
        chars_seen++;
      end
    end
    pending = text_q.size();
  end

endmodule

/* test/tb_unsigned_integer_ascii_formatter.sv */
// Top of the formatter testbench: clock, reset, request and receive traffic,
// watchdog and verdict. Depends on uiaf_pkg, the formatter RTL and uiaf_text_checker.
module tb_unsigned_integer_ascii_formatter import uiaf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 200;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] value;
    logic [1:0]  len;
    logic        zpad;
    logic        alt;
    logic [6:0]  width;
    logic [6:0]  prec;
  } fmt_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  mode = MODE_DEC;
  logic [63:0] value = 64'd0;
  logic [1:0]  length_kind = LEN_32;
  logic        zero_pad_flag = 1'b0;
  logic        alt_form_flag = 1'b0;
  logic [6:0]  field_width = 7'd0;
  logic [6:0]  min_digits = 7'd0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [6:0]  char_code;
  logic        last_char;

  int errors, pending, chars_seen;
  int items_sent = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;

  unsigned_integer_ascii_formatter dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .value(value), .length_kind(length_kind),
    .zero_pad_flag(zero_pad_flag), .alt_form_flag(alt_form_flag),
    .field_width(field_width), .min_digits(min_digits),
    .out_valid(out_valid), .out_stall(out_stall),
    .char_code(char_code), .last_char(last_char)
  );

  uiaf_text_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .value(value), .length_kind(length_kind),
    .zero_pad_flag(zero_pad_flag), .alt_form_flag(alt_form_flag),
    .field_width(field_width), .min_digits(min_digits),
    .out_valid(out_valid), .out_stall(out_stall),
    .char_code(char_code), .last_char(last_char),
    .errors(errors), .pending(pending), .chars_seen(chars_seen)
  );

  always #1 clk = ~clk;

  function automatic fmt_req_t make_request(input logic [1:0] md, input logic [63:0] v,
                                            input logic [1:0] lk, input logic zp,
                                            input logic af, input int w, input int p);
    fmt_req_t r;
    r.mode  = md;
    r.value = v;
    r.len   = lk;
    r.zpad  = zp;
    r.alt   = af;
    r.width = w[6:0];
    r.prec  = p[6:0];
    return r;
  endfunction

  // random request: mostly modest widths and precisions, some over the full field range
  function automatic fmt_req_t rand_request();
    fmt_req_t r;
    int pick;
    r.mode = 2'($urandom_range(0, 3));
    r.len  = 2'($urandom_range(0, 3));
    r.zpad = 1'($urandom_range(0, 1));
    r.alt  = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    case (pick)
      0:       r.value = 64'd0;
      1:       r.value = '1;
      2:       r.value = 64'($urandom_range(0, 255));
      3:       r.value = 64'd1 << $urandom_range(0, 63);
      4, 5:    r.value = {32'd0, $urandom};
      default: r.value = {$urandom, $urandom};
    endcase
    r.width = ($urandom_range(0, 9) < 8) ? 7'($urandom_range(0, 24))
                                         : 7'($urandom_range(0, 127));
    pick = $urandom_range(0, 9);
    if (pick < 4) r.prec = 7'h7F;
    else if (pick < 7) r.prec = 7'($urandom_range(0, 12));
    else if (pick < 8) r.prec = 7'd0;
    else r.prec = 7'($urandom_range(0, 127));
    return r;
  endfunction

  // one request transfer; called and returns at a falling edge
  task automatic drive_request(input fmt_req_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    mode <= r.mode;
    value <= r.value;
    length_kind <= r.len;
    zero_pad_flag <= r.zpad;
    alt_form_flag <= r.alt;
    field_width <= r.width;
    min_digits <= r.prec;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // reset
  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
  end

  // receiver: per-character stall draw, plus one long hold-off on request
  initial begin : receiver
    int gap;
    wait (!rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d chars pending",
                 idle_cycles, pending);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    fmt_req_t directed [$];
    int n_directed;
    wait (!rst);

    // corner cases
    directed.push_back(make_request(MODE_DEC, 64'd0, LEN_32, 1'b0, 1'b0, 0, -1));
    directed.push_back(make_request(MODE_DEC, 64'd0, LEN_32, 1'b1, 1'b1, 10, 0));
    directed.push_back(make_request(MODE_HEXLO, 64'd0, LEN_64, 1'b0, 1'b1, 4, -1));
    directed.push_back(make_request(MODE_OCT, 64'd0, LEN_16, 1'b1, 1'b1, 5, -1));
    directed.push_back(make_request(MODE_DEC, '1, LEN_64, 1'b0, 1'b0, 0, -1));
    directed.push_back(make_request(MODE_OCT, '1, LEN_64, 1'b0, 1'b1, 0, -1));
    directed.push_back(make_request(MODE_HEXUP, '1, LEN_64, 1'b1, 1'b1, 64, -1));
    directed.push_back(make_request(MODE_HEXLO, 64'h1234_5678_9abc_def0, LEN_16,
                                    1'b0, 1'b0, 0, -1));
    directed.push_back(make_request(MODE_DEC, 64'hffff_ffff_ffff_ffff, LEN_32,
                                    1'b0, 1'b0, 12, -1));
    directed.push_back(make_request(MODE_HEXUP, 64'hdead_beef_cafe_f00d, 2'd3,
                                    1'b0, 1'b1, 0, -1));
    directed.push_back(make_request(MODE_OCT, 64'd8, LEN_32, 1'b0, 1'b1, 0, 5));
    directed.push_back(make_request(MODE_HEXLO, 64'hab, LEN_32, 1'b1, 1'b1, 12, -1));
    directed.push_back(make_request(MODE_HEXLO, 64'hab, LEN_32, 1'b0, 1'b1, 12, -1));
    directed.push_back(make_request(MODE_DEC, 64'd7, LEN_32, 1'b1, 1'b0, 10, 3));
    directed.push_back(make_request(MODE_DEC, 64'd42, LEN_32, 1'b0, 1'b1, 6, -1));
    directed.push_back(make_request(MODE_DEC, 64'd5, LEN_16, 1'b0, 1'b0, 127, -1));
    directed.push_back(make_request(MODE_DEC, 64'd1, LEN_64, 1'b0, 1'b0, 0, 63));
    directed.push_back(make_request(MODE_HEXLO, 64'd3, LEN_32, 1'b1, 1'b0, 8, -64));
    directed.push_back(make_request(MODE_HEXUP, 64'hf, LEN_64, 1'b0, 1'b1, 64, 62));
    directed.push_back(make_request(MODE_DEC, 64'd1, LEN_32, 1'b1, 1'b0, 64, -1));
    directed.push_back(make_request(MODE_DEC, 64'hffff, LEN_16, 1'b0, 1'b0, 0, -1));
    directed.push_back(make_request(MODE_HEXUP, 64'h1f, LEN_32, 1'b0, 1'b0, 0, 0));
    directed.push_back(make_request(MODE_OCT, 64'h8000_0000_0000_0000, LEN_64,
                                    1'b1, 1'b0, 30, -1));
    n_directed = directed.size();
    foreach (directed[i]) drive_request(directed[i]);

    // random traffic with idling on both sides
    repeat (100) drive_request(rand_request());

    // long output hold-off while requests keep coming, so the input backs up
    hold_req = 1'b1;
    no_idle = 1'b1;
    repeat (24) drive_request(rand_request());
    no_idle = 1'b0;

    // pause until every character has come out
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);

    // stretch with no idling on either side
    no_idle = 1'b1;
    repeat (50) drive_request(rand_request());
    no_idle = 1'b0;

    repeat (126) drive_request(rand_request());

    // drain
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d requests (%0d directed) across all bases, length kinds and flags.",
             items_sent, n_directed);
    $display("Compared %0d characters, with one long output hold-off and one full drain.",
             chars_seen);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* unsigned_integer_ascii_formatter.f */
+incdir+rtl
rtl/uiaf_pkg.sv
rtl/uiaf_queue.sv
rtl/uiaf_front.sv
rtl/uiaf_back.sv
rtl/unsigned_integer_ascii_formatter.sv
test/uiaf_text_checker.sv
test/tb_unsigned_integer_ascii_formatter.sv
